[rtl/lzbd_pkg.sv]
// Package for the LZ4 block sequence decoder: phase and status codes,
// window constants and the structs passed between control, window and packer.
// No dependencies.
`default_nettype none

package lzbd_pkg;

  localparam int unsigned WIN_BYTES = 65536;
  localparam int unsigned WIN_AW    = 16;
  localparam int unsigned BSIZE_W   = 23;
  localparam int unsigned MAX_RES   = 32;

  localparam logic [3:0] NIB_EXT   = 4'hF;
  localparam logic [7:0] BYTE_EXT  = 8'hFF;
  localparam logic [7:0] MATCH_MIN = 8'd4;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_LITLEN,
    PH_LITRUN,
    PH_OFFLO,
    PH_OFFHI,
    PH_MATCHLEN,
    PH_DONE,
    PH_ERROR
  } lzbd_phase_t;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } lzbd_status_t;

  typedef struct packed {
    logic         vld;
    logic         empty;
    logic         last;
    logic [7:0]   data;
    lzbd_status_t status;
  } lzbd_pack_req_t;

  typedef struct packed {
    logic emit;
    logic add;
  } lzbd_pack_rdy_t;

  typedef struct packed {
    logic              wr_en;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [WIN_AW-1:0] off;
  } lzbd_win_req_t;

endpackage

`default_nettype wire

[rtl/lzbd_if.sv]
// Valid/ready channel interfaces: compressed byte input, decoded result
// output and block size configuration. Depends on lzbd_pkg.
`default_nettype none

interface lzbd_byte_if ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzbd_res_if ();
  logic        valid;
  logic        ready;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic        run_last;
  logic [1:0]  status;

  modport source (output valid, output out_data, output out_count, output run_last,
                  output status, input ready);
  modport sink   (input valid, input out_data, input out_count, input run_last,
                  input status, output ready);
endinterface

interface lzbd_cfg_if import lzbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BSIZE_W-1:0] block_size;

  modport source (output valid, output block_size, input ready);
  modport sink   (input valid, input block_size, output ready);
endinterface

`default_nettype wire

[rtl/lz4_block_sequence_decoder.sv]
// Top level of the LZ4 block sequence decoder: control, history window and
// result packer. Depends on lzbd_pkg, lzbd_if, lzbd_ctrl, lzbd_window, lzbd_packer.
//
//   channel  dir  payload                                  transaction
//   in_ch    in   in_byte[7:0]                             one compressed byte
//   out_ch   out  out_data[63:0] out_count run_last status one result word
//   cfg_ch   in   block_size[22:0]                         start a new block
//
// Token, length, offset and literal bytes are accepted only while no match copy is pending and the packer can emit.
// A match of n bytes is copied with one window read per byte through the read port.
// Unwritten window bytes read as zero through a fill count; no clearing pass after reset.
// rst_n is synchronous; cfg_ch is always ready and takes effect on the next edge.
// A stalled out_ch holds in_ch, and the copy engine once a word is complete; not while results are dropped.
`default_nettype none

module lz4_block_sequence_decoder import lzbd_pkg::*; #(
  parameter int unsigned BYTES_PER_RESULT = 8,
  parameter int unsigned MAX_BLOCK_BYTES  = 4194304
) (
  input  logic              clk,
  input  logic              rst_n,
  lzbd_byte_if.sink         in_ch,
  lzbd_res_if.source        out_ch,
  lzbd_cfg_if.sink          cfg_ch
);

  lzbd_win_req_t  win_req;
  logic [7:0]     win_src;
  lzbd_pack_req_t pk_req;
  lzbd_pack_rdy_t pk_rdy;

  lzbd_ctrl #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.in_byte),
    .in_ready  (in_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_data  (cfg_ch.block_size),
    .cfg_ready (cfg_ch.ready),
    .win_req   (win_req),
    .win_src   (win_src),
    .pk_req    (pk_req),
    .pk_rdy    (pk_rdy)
  );

  lzbd_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (win_req),
    .src   (win_src)
  );

  lzbd_packer #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (pk_req),
    .rdy       (pk_rdy),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.out_data),
    .out_count (out_ch.out_count),
    .run_last  (out_ch.run_last),
    .status    (out_ch.status)
  );

endmodule

`default_nettype wire

[rtl/lzbd_window.sv]
// 64 KiB history window: single-port-write, single-port-read memory with a
// fill count for never-written bytes and forwarding for offset one. Depends on lzbd_pkg.
`default_nettype none

module lzbd_window import lzbd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  lzbd_win_req_t req,
  output logic [7:0]    src
);

  logic [7:0]        mem [WIN_BYTES];
  logic [7:0]        rdata_r;
  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic [WIN_AW:0]   fill_r, fill_nxt;
  logic [7:0]        prev_r, prev_nxt;
  logic [WIN_AW-1:0] rd_addr;

  always_comb begin
    rd_addr  = wp_r + WIN_AW'(req.wr_en) - req.off;
    wp_nxt   = req.wr_en ? wp_r + 1'b1 : wp_r;
    fill_nxt = (req.wr_en && fill_r != (WIN_AW+1)'(WIN_BYTES)) ? fill_r + 1'b1 : fill_r;
    prev_nxt = req.wr_en ? req.wr_data : prev_r;
    if ({1'b0, req.off} > fill_r) begin
      src = 8'h00;
    end else if (req.off == WIN_AW'(1)) begin
      src = prev_r;
    end else begin
      src = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wp_r] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      prev_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/lzbd_packer.sv]
// Result packer: gathers decoded bytes into words of up to BYTES_PER_RESULT
// bytes and holds them in the output register. Depends on lzbd_pkg.
`default_nettype none

module lzbd_packer import lzbd_pkg::*; #(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lzbd_pack_req_t req,
  output lzbd_pack_rdy_t rdy,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    out_data,
  output logic [3:0]     out_count,
  output logic           run_last,
  output logic [1:0]     status
);

  localparam logic [3:0] CHUNK = 4'(BYTES_PER_RESULT);
  localparam int unsigned RC_W = $clog2(MAX_RES + 1);

  logic                ov_r, ov_nxt;
  logic [63:0]         od_r, od_nxt;
  logic [3:0]          oc_r, oc_nxt;
  logic                ol_r, ol_nxt;
  lzbd_status_t        os_r, os_nxt;
  logic [63:0]         buf_r, buf_nxt;
  logic [2:0]          bcnt_r, bcnt_nxt;
  logic [RC_W-1:0]     rc_r, rc_nxt;
  logic                out_free;
  logic                drop;
  logic [3:0]          ncnt;
  logic [63:0]         merged;

  always_comb begin
    out_free = !ov_r || out_ready;
    drop     = rc_r == RC_W'(MAX_RES);
    ncnt     = {1'b0, bcnt_r} + 4'd1;
    rdy.emit = out_free || drop;
    rdy.add  = rdy.emit || (ncnt < CHUNK);
    for (int i = 0; i < 8; i++) begin
      merged[8*i +: 8] = (3'(i) == bcnt_r) ? req.data : buf_r[8*i +: 8];
    end

    ov_nxt   = ov_r;
    od_nxt   = od_r;
    oc_nxt   = oc_r;
    ol_nxt   = ol_r;
    os_nxt   = os_r;
    buf_nxt  = buf_r;
    bcnt_nxt = bcnt_r;
    rc_nxt   = rc_r;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    if (req.vld) begin
      if (req.empty) begin
        ov_nxt = 1'b1;
        od_nxt = '0;
        oc_nxt = '0;
        ol_nxt = 1'b1;
        os_nxt = req.status;
      end else if (!drop) begin
        if (ncnt == CHUNK || req.last) begin
          ov_nxt   = 1'b1;
          od_nxt   = merged;
          oc_nxt   = ncnt;
          ol_nxt   = req.last || rc_r == RC_W'(MAX_RES - 1);
          os_nxt   = req.status;
          buf_nxt  = '0;
          bcnt_nxt = '0;
          rc_nxt   = rc_r + 1'b1;
        end else begin
          buf_nxt  = merged;
          bcnt_nxt = ncnt[2:0];
        end
      end
      if (req.last) begin
        rc_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      buf_r  <= '0;
      bcnt_r <= '0;
      rc_r   <= '0;
    end else begin
      ov_r   <= ov_nxt;
      buf_r  <= buf_nxt;
      bcnt_r <= bcnt_nxt;
      rc_r   <= rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    oc_r <= oc_nxt;
    ol_r <= ol_nxt;
    os_r <= os_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_count = oc_r;
  assign run_last  = ol_r;
  assign status    = os_r;

endmodule

`default_nettype wire

[rtl/lzbd_ctrl.sv]
// Sequence control: token/length/offset phase machine, block byte count,
// match copy engine driving the window read port. Depends on lzbd_pkg.
`default_nettype none

module lzbd_ctrl import lzbd_pkg::*; #(
  parameter int unsigned MAX_BLOCK_BYTES = 4194304
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  output logic               in_ready,
  input  logic               cfg_valid,
  input  logic [BSIZE_W-1:0] cfg_data,
  output logic               cfg_ready,
  output lzbd_win_req_t      win_req,
  input  logic [7:0]         win_src,
  output lzbd_pack_req_t     pk_req,
  input  lzbd_pack_rdy_t     pk_rdy
);

  localparam logic [BSIZE_W-1:0] MAX_BS = BSIZE_W'(MAX_BLOCK_BYTES);

  lzbd_phase_t        phase_r, phase_nxt;
  logic [31:0]        lit_rem_r, lit_rem_nxt;
  logic [3:0]         mnib_r, mnib_nxt;
  logic [15:0]        off_r, off_nxt;
  logic [BSIZE_W-1:0] cons_r, cons_nxt;
  logic [BSIZE_W-1:0] bsize_r, bsize_nxt;
  logic [7:0]         cp_rem_r, cp_rem_nxt;
  logic               av_r, av_nxt;
  logic               alast_r, alast_nxt;

  logic               idle;
  logic               in_fire;
  logic               consume;
  logic               issue;
  logic [32:0]        lit_sum;
  logic [BSIZE_W-1:0] cons_inc;
  logic [15:0]        off_full;

  always_comb begin
    phase_nxt   = phase_r;
    lit_rem_nxt = lit_rem_r;
    mnib_nxt    = mnib_r;
    off_nxt     = off_r;
    cons_nxt    = cons_r;
    bsize_nxt   = bsize_r;
    cp_rem_nxt  = cp_rem_r;
    av_nxt      = av_r;
    alast_nxt   = alast_r;

    idle      = cp_rem_r == 8'd0 && !av_r;
    in_ready  = idle && pk_rdy.emit;
    cfg_ready = 1'b1;
    in_fire   = in_valid && in_ready;
    consume   = av_r && (alast_r ? pk_rdy.emit : pk_rdy.add);
    issue     = cp_rem_r != 8'd0 && (!av_r || consume);
    lit_sum   = {1'b0, lit_rem_r} + 33'(in_byte);
    cons_inc  = cons_r + 1'b1;
    off_full  = {in_byte, off_r[7:0]};

    pk_req          = '0;
    pk_req.status   = ST_RUN;
    win_req         = '0;
    win_req.off     = off_r;
    win_req.rd_en   = issue;

    if (issue) begin
      cp_rem_nxt = cp_rem_r - 8'd1;
      av_nxt     = 1'b1;
      alast_nxt  = cp_rem_r == 8'd1;
    end else if (consume) begin
      av_nxt = 1'b0;
    end

    if (consume) begin
      pk_req.vld      = 1'b1;
      pk_req.data     = win_src;
      pk_req.last     = alast_r;
      win_req.wr_en   = 1'b1;
      win_req.wr_data = win_src;
    end

    if (in_fire) begin
      pk_req.vld   = 1'b1;
      pk_req.empty = 1'b1;
      pk_req.last  = 1'b1;
      if (phase_r == PH_DONE) begin
        pk_req.status = ST_DONE;
      end else if (phase_r == PH_ERROR) begin
        pk_req.status = ST_ERR;
      end else if (cons_r >= bsize_r) begin
        phase_nxt     = PH_ERROR;
        pk_req.status = ST_ERR;
      end else begin
        cons_nxt = cons_inc;
        case (phase_r)
          PH_TOKEN: begin
            mnib_nxt    = in_byte[3:0];
            lit_rem_nxt = 32'(in_byte[7:4]);
            if (in_byte[7:4] == 4'd0) begin
              phase_nxt = PH_OFFLO;
            end else if (in_byte[7:4] == NIB_EXT) begin
              phase_nxt = PH_LITLEN;
            end else begin
              phase_nxt = PH_LITRUN;
            end
          end
          PH_LITLEN: begin
            lit_rem_nxt = lit_sum[32] ? '1 : lit_sum[31:0];
            if (in_byte != BYTE_EXT) begin
              phase_nxt = PH_LITRUN;
            end
          end
          PH_LITRUN: begin
            win_req.wr_en   = 1'b1;
            win_req.wr_data = in_byte;
            pk_req.empty    = 1'b0;
            pk_req.data     = in_byte;
            if (lit_rem_r != 32'd0) begin
              lit_rem_nxt = lit_rem_r - 32'd1;
            end
            if (lit_rem_r <= 32'd1) begin
              if (cons_inc == bsize_r) begin
                phase_nxt     = PH_DONE;
                pk_req.status = ST_DONE;
              end else begin
                phase_nxt = PH_OFFLO;
              end
            end
          end
          PH_OFFLO: begin
            off_nxt   = {8'h00, in_byte};
            phase_nxt = PH_OFFHI;
          end
          PH_OFFHI: begin
            off_nxt = off_full;
            if (off_full == 16'd0) begin
              phase_nxt     = PH_ERROR;
              pk_req.status = ST_ERR;
            end else begin
              pk_req.vld = 1'b0;
              cp_rem_nxt = 8'(mnib_r) + MATCH_MIN;
              phase_nxt  = (mnib_r == NIB_EXT) ? PH_MATCHLEN : PH_TOKEN;
            end
          end
          PH_MATCHLEN: begin
            if (in_byte != 8'd0) begin
              pk_req.vld = 1'b0;
              cp_rem_nxt = in_byte;
            end
            if (in_byte != BYTE_EXT) begin
              phase_nxt = PH_TOKEN;
            end
          end
          default: begin
            phase_nxt     = PH_ERROR;
            pk_req.status = ST_ERR;
          end
        endcase
      end
    end

    if (cfg_valid) begin
      bsize_nxt   = (cfg_data > MAX_BS) ? MAX_BS : cfg_data;
      phase_nxt   = PH_TOKEN;
      lit_rem_nxt = '0;
      mnib_nxt    = '0;
      off_nxt     = '0;
      cons_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TOKEN;
      lit_rem_r <= '0;
      mnib_r    <= '0;
      off_r     <= '0;
      cons_r    <= '0;
      bsize_r   <= '0;
      cp_rem_r  <= '0;
      av_r      <= 1'b0;
      alast_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      lit_rem_r <= lit_rem_nxt;
      mnib_r    <= mnib_nxt;
      off_r     <= off_nxt;
      cons_r    <= cons_nxt;
      bsize_r   <= bsize_nxt;
      cp_rem_r  <= cp_rem_nxt;
      av_r      <= av_nxt;
      alast_r   <= alast_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/lzbd_checker.sv]
// Port-level checker for lz4_block_sequence_decoder, bound to the top level.
// Depends on lzbd_pkg.
`default_nettype none

module lzbd_checker import lzbd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_data,
  input logic [3:0]  out_count,
  input logic        run_last,
  input logic [1:0]  status,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  logic err_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      err_seen_r <= 1'b0;
    end else if (out_valid && out_ready && status == ST_ERR) begin
      err_seen_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data) && $stable(out_count) &&
                                $stable(run_last) && $stable(status))
    else $error("result payload changed while stalled");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |-> status == ST_ERR)
    else $error("status left error without a new block");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == 4'd0 |-> run_last && out_data == 64'd0)
    else $error("empty result not final or not zero");

endmodule

bind lz4_block_sequence_decoder lzbd_checker u_lzbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.out_data),
  .out_count (out_ch.out_count),
  .run_last  (out_ch.run_last),
  .status    (out_ch.status),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready)
);

`default_nettype wire
